/* rtl/core/idm_speed_update_defines.svh */
// Assertion macros shared by the speed update block.
// Depends on nothing; the user must have clk and rst_n in scope.
`ifndef IDM_SPEED_UPDATE_DEFINES_SVH
`define IDM_SPEED_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IDM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/idm_pkg.sv */
// Package for the speed update block: constants, codes, types and helpers.
// Used by every module of the block.
package idm_pkg;

  localparam int DEF_MAX_SUB_STEPS = 16;
  localparam int DEF_MAX_EXPONENT  = 8;

  localparam logic signed [63:0] Q_ONE = 64'sd65536;
  localparam logic [31:0] STOP_GAP_LIMIT = 32'd656;
  localparam logic [23:0] MASK24 = 24'hFFFFFF;

  typedef enum logic [2:0] {
    REG_MAX_ACCEL  = 3'd0,
    REG_INV_COMF   = 3'd1,
    REG_HEADWAY    = 3'd2,
    REG_MIN_GAP    = 3'd3,
    REG_SPEED_EXP  = 3'd4,
    REG_ADAPT      = 3'd5,
    REG_STEP_LEN   = 3'd6,
    REG_SUB_STEPS  = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    U_H0, U_H1, U_S0, U_S1, U_S2, U_R, U_P, U_G, U_Q, U_A, U_X, U_V, U_D, U_N
  } ustep_t;

  typedef struct packed {
    logic [23:0] max_accel;
    logic [23:0] inv_comfort;
    logic [23:0] headway;
    logic [23:0] min_gap;
    logic [3:0]  speed_exp;
    logic [23:0] adapt;
    logic [23:0] step_len;
    logic [4:0]  sub_steps;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic               is_div;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } arith_req_t;

  function automatic logic signed [63:0] sat64(input logic signed [63:0] x,
                                               input logic signed [63:0] lim);
    logic signed [63:0] r;
    r = x;
    if (x > lim) r = lim;
    if (x < -lim) r = -lim;
    return r;
  endfunction

endpackage

/* rtl/core/idm_cfg.sv */
// Configuration register file of the speed update block.
// Depends on idm_pkg.
module idm_cfg import idm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [23:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_accel   <= 24'd170394;
      cfg_r.inv_comfort <= 24'd9581;
      cfg_r.headway     <= 24'd65536;
      cfg_r.min_gap     <= 24'd163840;
      cfg_r.speed_exp   <= 4'd4;
      cfg_r.adapt       <= 24'd65536;
      cfg_r.step_len    <= 24'd65536;
      cfg_r.sub_steps   <= 5'd4;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_MAX_ACCEL: cfg_r.max_accel   <= wr_data;
        REG_INV_COMF:  cfg_r.inv_comfort <= wr_data;
        REG_HEADWAY:   cfg_r.headway     <= wr_data;
        REG_MIN_GAP:   cfg_r.min_gap     <= wr_data;
        REG_SPEED_EXP: cfg_r.speed_exp   <= wr_data[3:0];
        REG_ADAPT:     cfg_r.adapt       <= wr_data;
        REG_STEP_LEN:  cfg_r.step_len    <= wr_data;
        REG_SUB_STEPS: cfg_r.sub_steps   <= wr_data[4:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/idm_arith.sv */
// Shared bit-serial signed multiplier and divider, one bit per cycle.
// Depends on idm_pkg. Products are scaled by 2^-16, both truncate toward zero.
module idm_arith import idm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  arith_req_t         req,
  output logic               busy,
  output logic               done,
  output logic signed [63:0] res
);

  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        div_r, neg_r;
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt, acc_r, acc_nxt;
  logic [63:0] abs_a, abs_b, rem_s, mag;
  logic signed [63:0] sa, sb;

  always_comb begin
    sa = $signed(req.a);
    sb = $signed(req.b);
    abs_a = sa[63] ? 64'(-sa) : 64'(sa);
    abs_b = sb[63] ? 64'(-sb) : 64'(sb);
    rem_s = {acc_r[62:0], ma_r[63]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    acc_nxt = acc_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt = 6'd63;
      ma_nxt = abs_a;
      mb_nxt = abs_b;
      acc_nxt = '0;
    end else if (busy_r) begin
      if (div_r) begin
        if (rem_s >= mb_r) begin
          acc_nxt = rem_s - mb_r;
          ma_nxt = {ma_r[62:0], 1'b1};
        end else begin
          acc_nxt = rem_s;
          ma_nxt = {ma_r[62:0], 1'b0};
        end
      end else begin
        if (ma_r[0]) acc_nxt = acc_r + mb_r;
        ma_nxt = {1'b0, ma_r[63:1]};
        mb_nxt = {mb_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    if (req.start && !busy_r) begin
      div_r <= req.is_div;
      neg_r <= sa[63] ^ sb[63];
    end
  end

  assign mag  = div_r ? ma_r : (acc_r >> 16);
  assign res  = neg_r ? -$signed(mag) : $signed(mag);
  assign busy = busy_r;
  assign done = done_r;

endmodule

/* rtl/core/idm_speed_update.sv */
// Next-speed unit for car following: a sequencer drives one shared
// bit-serial multiply/divide unit. A request issues h + n * (11 + e)
// operations, n sub-steps, e the exponent, h two with headway adaptation and
// zero without; a sub-step with a zero gap skips its gap division. Special
// cases issue no operation. The input is not ready meanwhile, and a result
// held back by out_tready stalls the block.
module idm_speed_update import idm_pkg::*; #(
  parameter int MAX_SUB_STEPS = DEF_MAX_SUB_STEPS,
  parameter int MAX_EXPONENT  = DEF_MAX_EXPONENT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ego_speed[23:0], gap[55:24], pred_speed[79:56], desired_speed[103:80],
  // level_of_service[120:104], zero fill to 128.
  input  logic [127:0] in_tdata,
  // action
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_speed[23:0]
  output logic [23:0]  out_tdata,
  // clamped_to_zero
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

`include "idm_speed_update_defines.svh"

  localparam int NW = $clog2(MAX_SUB_STEPS + 1);
  localparam int EW = $clog2(MAX_EXPONENT + 1);
  localparam logic signed [63:0] LIM20 = 64'sd1 <<< 20;
  localparam logic signed [63:0] LIM24 = 64'sd1 <<< 24;
  localparam logic signed [63:0] LIM32 = 64'sd1 <<< 32;
  localparam logic signed [63:0] LIM36 = 64'sd1 <<< 36;
  localparam logic signed [63:0] LIM40 = 64'sd1 <<< 40;
  localparam logic signed [63:0] VMAX  = 64'sd16777215;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  ustep_t ustep_r, ustep_nxt;
  cfg_t cfg;
  arith_req_t req;
  logic arith_busy, arith_done;
  logic signed [63:0] ar;

  logic               stop_r, stop_nxt;
  logic signed [25:0] v_r, v_nxt;
  logic signed [39:0] gap_r, gap_nxt;
  logic [23:0]        pred_r, pred_nxt, des_r, des_nxt, hw_r, hw_nxt;
  logic [16:0]        los_r, los_nxt;
  logic signed [44:0] s_r, s_nxt;
  logic signed [21:0] r_r, r_nxt;
  logic signed [41:0] p_r, p_nxt;
  logic [24:0]        g_r, g_nxt;
  logic signed [37:0] t_r, t_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic signed [63:0] tmp_r, tmp_nxt;
  logic [NW-1:0]      i_r, i_nxt, n_eff;
  logic [EW-1:0]      k_r, k_nxt, e_eff;
  logic [23:0]        res_speed_r, res_speed_nxt;
  logic               res_clamp_r, res_clamp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [23:0]        out_speed_r;
  logic               out_clamp_r;

  logic in_accept, out_load;
  logic [23:0] in_ego, in_pred, in_des;
  logic [31:0] in_gap;
  logic [16:0] in_los;
  logic signed [63:0] v64, pred64, gap64, agap, sum;

  idm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  idm_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .busy  (arith_busy),
    .done  (arith_done),
    .res   (ar)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_WRITE) && (!out_valid_r || out_tready);

  assign in_ego  = in_tdata[23:0];
  assign in_gap  = in_tdata[55:24];
  assign in_pred = in_tdata[79:56];
  assign in_des  = in_tdata[103:80];
  assign in_los  = in_tdata[120:104];

  always_comb begin
    if (cfg.sub_steps == 5'd0) n_eff = NW'(1);
    else if (32'(cfg.sub_steps) > MAX_SUB_STEPS) n_eff = NW'(MAX_SUB_STEPS);
    else n_eff = NW'(cfg.sub_steps);
    if (32'(cfg.speed_exp) > MAX_EXPONENT) e_eff = EW'(MAX_EXPONENT);
    else e_eff = EW'(cfg.speed_exp);
  end

  assign v64    = 64'(v_r);
  assign pred64 = $signed(64'(pred_r));
  assign gap64  = 64'(gap_r);
  assign agap   = gap64[63] ? -gap64 : gap64;

  always_comb begin
    req.start  = 1'b0;
    req.is_div = 1'b0;
    req.a      = '0;
    req.b      = '0;
    if (state_r == ST_ISSUE && !(ustep_r == U_G && agap == 64'sd0)) begin
      req.start = 1'b1;
      case (ustep_r)
        U_H0: begin
          req.a = $signed(64'(cfg.adapt));
          req.b = Q_ONE - $signed(64'(los_r));
        end
        U_H1: begin
          req.a = $signed(64'(hw_r));
          req.b = tmp_r;
        end
        U_S0: begin
          req.a = v64;
          req.b = $signed(64'(hw_r));
        end
        U_S1: begin
          req.a = v64;
          req.b = v64 - pred64;
        end
        U_S2: begin
          req.a = tmp_r;
          req.b = $signed(64'(cfg.inv_comfort));
        end
        U_R: begin
          req.is_div = 1'b1;
          req.a = v64 <<< 16;
          req.b = $signed(64'(des_r));
        end
        U_P: begin
          req.a = 64'(p_r);
          req.b = 64'(r_r);
        end
        U_G: begin
          req.is_div = 1'b1;
          req.a = 64'(s_r) <<< 16;
          req.b = agap;
        end
        U_Q: begin
          req.a = $signed(64'(g_r));
          req.b = $signed(64'(g_r));
        end
        U_A: begin
          req.a = $signed(64'(cfg.max_accel));
          req.b = 64'(t_r);
        end
        U_X: begin
          req.a = 64'(acc_r);
          req.b = $signed(64'(cfg.step_len));
        end
        U_V: begin
          req.is_div = 1'b1;
          req.a = tmp_r;
          req.b = $signed(64'(n_eff));
        end
        U_D: begin
          req.a = v64 - pred64;
          req.b = $signed(64'(cfg.step_len));
        end
        U_N: begin
          req.is_div = 1'b1;
          req.a = tmp_r;
          req.b = $signed(64'(n_eff));
        end
        default: req.start = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    ustep_nxt = ustep_r;
    stop_nxt = stop_r;
    v_nxt = v_r;
    gap_nxt = gap_r;
    pred_nxt = pred_r;
    des_nxt = des_r;
    hw_nxt = hw_r;
    los_nxt = los_r;
    s_nxt = s_r;
    r_nxt = r_r;
    p_nxt = p_r;
    g_nxt = g_r;
    t_nxt = t_r;
    acc_nxt = acc_r;
    tmp_nxt = tmp_r;
    i_nxt = i_r;
    k_nxt = k_r;
    res_speed_nxt = res_speed_r;
    res_clamp_nxt = res_clamp_r;
    sum = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          stop_nxt = in_tuser;
          v_nxt = $signed({2'b00, in_ego});
          gap_nxt = $signed({8'd0, in_gap});
          pred_nxt = in_tuser ? 24'd0 : in_pred;
          des_nxt = in_des;
          hw_nxt = cfg.headway;
          los_nxt = (in_los > 17'd65536) ? 17'd65536 : in_los;
          i_nxt = '0;
          if (in_des == 24'd0 || in_gap == 32'd0 ||
              (in_tuser && in_gap < STOP_GAP_LIMIT)) begin
            res_speed_nxt = 24'd0;
            res_clamp_nxt = 1'b1;
            state_nxt = ST_WRITE;
          end else begin
            ustep_nxt = (cfg.adapt != 24'd65536) ? U_H0 : U_S0;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (ustep_r == U_G && agap == 64'sd0) begin
          g_nxt = 25'(LIM24);
          ustep_nxt = U_Q;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (arith_done) begin
          state_nxt = ST_ISSUE;
          case (ustep_r)
            U_H0: begin
              tmp_nxt = ar + $signed(64'(los_r));
              ustep_nxt = U_H1;
            end
            U_H1: begin
              hw_nxt = (ar > VMAX) ? MASK24 : ar[23:0];
              ustep_nxt = U_S0;
            end
            U_S0: begin
              s_nxt = ar[44:0];
              ustep_nxt = U_S1;
            end
            U_S1: begin
              tmp_nxt = ar;
              ustep_nxt = U_S2;
            end
            U_S2: begin
              sum = 64'(s_r) + ar;
              if (sum < 0) sum = '0;
              if (!stop_r) sum = sum + $signed(64'(cfg.min_gap));
              s_nxt = sum[44:0];
              ustep_nxt = U_R;
            end
            U_R: begin
              sum = sat64(ar, LIM20);
              r_nxt = sum[21:0];
              p_nxt = 42'(Q_ONE);
              k_nxt = '0;
              ustep_nxt = (e_eff == '0) ? U_G : U_P;
            end
            U_P: begin
              sum = sat64(ar, LIM40);
              p_nxt = sum[41:0];
              k_nxt = k_r + EW'(1);
              if (k_r + EW'(1) == e_eff) ustep_nxt = U_G;
            end
            U_G: begin
              g_nxt = (ar > LIM24) ? 25'(LIM24) : ar[24:0];
              ustep_nxt = U_Q;
            end
            U_Q: begin
              sum = sat64(Q_ONE - 64'(p_r) - ar, LIM36);
              t_nxt = sum[37:0];
              ustep_nxt = U_A;
            end
            U_A: begin
              sum = sat64(ar, LIM32);
              acc_nxt = sum[33:0];
              ustep_nxt = U_X;
            end
            U_X: begin
              tmp_nxt = ar;
              ustep_nxt = U_V;
            end
            U_V: begin
              sum = sat64(v64 + ar, VMAX);
              v_nxt = sum[25:0];
              ustep_nxt = U_D;
            end
            U_D: begin
              tmp_nxt = ar;
              ustep_nxt = U_N;
            end
            U_N: begin
              if (ar > 0) gap_nxt = gap_r - ar[39:0];
              i_nxt = i_r + NW'(1);
              ustep_nxt = U_S0;
              if (i_r + NW'(1) == n_eff) begin
                state_nxt = ST_WRITE;
                if (v_r < 0) begin
                  res_speed_nxt = 24'd0;
                  res_clamp_nxt = 1'b1;
                end else begin
                  res_speed_nxt = v_r[23:0];
                  res_clamp_nxt = 1'b0;
                end
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ustep_r     <= U_S0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      ustep_r     <= ustep_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stop_r      <= stop_nxt;
    v_r         <= v_nxt;
    gap_r       <= gap_nxt;
    pred_r      <= pred_nxt;
    des_r       <= des_nxt;
    hw_r        <= hw_nxt;
    los_r       <= los_nxt;
    s_r         <= s_nxt;
    r_r         <= r_nxt;
    p_r         <= p_nxt;
    g_r         <= g_nxt;
    t_r         <= t_nxt;
    acc_r       <= acc_nxt;
    tmp_r       <= tmp_nxt;
    res_speed_r <= res_speed_nxt;
    res_clamp_r <= res_clamp_nxt;
    if (out_load) begin
      out_speed_r <= res_speed_r;
      out_clamp_r <= res_clamp_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_speed_r;
  assign out_tuser  = out_clamp_r;

  `IDM_ASSERT_IMPLY(a_start_idle, req.start, !arith_busy, "operation issued to busy unit")
  `IDM_ASSERT_NEXT(a_accept_busy, in_accept, !in_tready, "ready held after a transfer")
  `IDM_ASSERT_IMPLY(a_done_wait, arith_done, state_r == ST_WAIT, "result with nobody waiting")

endmodule
